// ===== rtl/fts_pkg.sv =====
// ----------------------------------------------------------------------------
// fts_pkg: shared definitions for the Fenwick tree prefix-sum unit
// Field widths, register map, microcode step and condition codes, and the
// control store of the sequencer.
// ----------------------------------------------------------------------------
package fts_pkg;

    // Fixed field widths of the beats and the register
    localparam int POS_W     = 10;
    localparam int AMT_W     = 32;
    localparam int SUM_OUT_W = 32;
    localparam int CNT_W     = 11;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    // Register index, taken from paddr[2]
    localparam logic REG_CELL_COUNT = 1'b0;

    // Defaults for the top-level parameters
    localparam int CELLS_DEFAULT     = 1024;
    localparam int SUM_WIDTH_DEFAULT = 32;

    // Microcode step addresses
    typedef enum logic [3:0] {
        U_CLEAR  = 4'd0,
        U_IDLE   = 4'd1,
        U_CHECK  = 4'd2,
        U_MODE   = 4'd3,
        U_AWALK  = 4'd4,
        U_QWALK  = 4'd5,
        U_ADRAIN = 4'd6,
        U_QDRAIN = 4'd7,
        U_QOUT   = 4'd8,
        U_BAD    = 4'd9,
        U_BOUT   = 4'd10
    } upc_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS    = 3'd0,
        C_IN_VALID  = 3'd1,
        C_POS_BAD   = 3'd2,
        C_QUERY     = 3'd3,
        C_UP_MORE   = 3'd4,
        C_DOWN_MORE = 3'd5,
        C_OUT_BUSY  = 3'd6,
        C_CLR_MORE  = 3'd7
    } cond_t;

    // One control word: datapath strobes, then the jump
    typedef struct packed {
        logic  in_ready;
        logic  clr;
        logic  rd_up;
        logic  rd_down;
        logic  out_ok;
        logic  out_bad;
        cond_t cond;
        upc_t  jt;
        upc_t  jf;
    } uword_t;

    // Control store
    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        w      = '0;
        w.cond = C_ALWAYS;
        w.jt   = U_IDLE;
        w.jf   = U_IDLE;
        case (pc)
            U_CLEAR:
            begin
                w.clr  = 1'b1;
                w.cond = C_CLR_MORE;
                w.jt   = U_CLEAR;
                w.jf   = U_IDLE;
            end
            U_IDLE:
            begin
                w.in_ready = 1'b1;
                w.cond     = C_IN_VALID;
                w.jt       = U_CHECK;
                w.jf       = U_IDLE;
            end
            U_CHECK:
            begin
                w.cond = C_POS_BAD;
                w.jt   = U_BAD;
                w.jf   = U_MODE;
            end
            U_MODE:
            begin
                w.cond = C_QUERY;
                w.jt   = U_QWALK;
                w.jf   = U_AWALK;
            end
            U_AWALK:
            begin
                w.rd_up = 1'b1;
                w.cond  = C_UP_MORE;
                w.jt    = U_AWALK;
                w.jf    = U_ADRAIN;
            end
            U_QWALK:
            begin
                w.rd_down = 1'b1;
                w.cond    = C_DOWN_MORE;
                w.jt      = U_QWALK;
                w.jf      = U_QDRAIN;
            end
            U_ADRAIN:
            begin
                w.jt = U_IDLE;
                w.jf = U_IDLE;
            end
            U_QDRAIN:
            begin
                w.jt = U_QOUT;
                w.jf = U_QOUT;
            end
            U_QOUT:
            begin
                w.out_ok = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.jt     = U_QOUT;
                w.jf     = U_IDLE;
            end
            U_BAD:
            begin
                w.cond = C_QUERY;
                w.jt   = U_BOUT;
                w.jf   = U_IDLE;
            end
            U_BOUT:
            begin
                w.out_bad = 1'b1;
                w.cond    = C_OUT_BUSY;
                w.jt      = U_BOUT;
                w.jf      = U_IDLE;
            end
            default:
            begin
                w.jt = U_IDLE;
                w.jf = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/fts_req_if.sv =====
// ----------------------------------------------------------------------------
// fts_req_if: request channel
// Valid/ready channel carrying one add or query beat.
// ----------------------------------------------------------------------------
interface fts_req_if;
    import fts_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [POS_W-1:0]        position;
    logic signed [AMT_W-1:0] amount;

    modport source (output valid, output mode, output position, output amount,
                    input ready);
    modport sink   (input valid, input mode, input position, input amount,
                    output ready);
endinterface

// ===== rtl/fts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fts_rsp_if: response channel
// Valid/ready channel carrying one prefix-sum beat.
// ----------------------------------------------------------------------------
interface fts_rsp_if;
    import fts_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [SUM_OUT_W-1:0] prefix_sum;
    logic                        out_of_range;

    modport source (output valid, output prefix_sum, output out_of_range,
                    input ready);
    modport sink   (input valid, input prefix_sum, input out_of_range,
                    output ready);
endinterface

// ===== rtl/fts_ram.sv =====
// ----------------------------------------------------------------------------
// fts_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/fenwick_tree_prefix_sum_unit.sv =====
// ----------------------------------------------------------------------------
// fenwick_tree_prefix_sum_unit: binary indexed tree over signed partial sums
// Steps: an add goes check, mode, walk, drain; a query goes check, mode,
//   walk, drain, output; a walk reads n tree entries (at most log2(CELLS) + 1,
//   eleven for 1024 cells), one entry per cycle through the RAM read port.
// Throughput: one item at a time; the next item is taken once the sequencer
//   is back in its idle step; a finished result waits in the output register.
// Reset: asynchronous, active low; the RAM is then swept to zero, cell by
//   cell, during which no request beat is taken; cell_count resets to 1024.
// ----------------------------------------------------------------------------
module fenwick_tree_prefix_sum_unit #(
    parameter int CELLS     = fts_pkg::CELLS_DEFAULT,
    parameter int SUM_WIDTH = fts_pkg::SUM_WIDTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fts_req_if.sink                     req,
    fts_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fts_pkg::APB_AW-1:0]  paddr,
    input  logic [fts_pkg::APB_DW-1:0]  pwdata,
    output logic [fts_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import fts_pkg::*;

    // RAM address width, and a walk index wide enough for pos+1, the cell
    // count itself and one upward step past it
    localparam int AW  = $clog2(CELLS);
    localparam int KW  = ($clog2(CELLS) + 2 > 12) ? $clog2(CELLS) + 2 : 12;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    upc_t                 upc_reg,       upc_next;
    logic [CNT_W-1:0]     cell_count_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic                 wpend_reg;     // write-back of an add step due
    logic                 apend_reg;     // accumulate of a query step due
    logic                 out_valid_reg, out_valid_next;

    logic                 mode_reg;
    logic [KW-1:0]        k_reg,         k_next;
    logic [SUM_WIDTH-1:0] amt_reg;
    logic [SUM_WIDTH-1:0] acc_reg,       acc_next;
    logic [AW-1:0]        wa_reg;
    logic [SUM_OUT_W-1:0] out_sum_reg;
    logic                 out_oor_reg;

    // ------------------------------------------------------------------
    // Control word and decoded conditions
    // ------------------------------------------------------------------
    uword_t               cw;
    logic                 cond_true;
    logic                 accept;
    logic                 out_busy;
    logic                 out_load;

    // Datapath values
    logic [KW-1:0]        len;
    logic [KW-1:0]        low_bit;
    logic [KW-1:0]        k_up;
    logic [KW-1:0]        k_down;
    logic [KW-1:0]        k_minus1;
    logic [63:0]          amt_wide;
    logic [63:0]          acc_wide;

    // RAM port
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SUM_WIDTH-1:0] ram_wdata;
    logic                 ram_re;
    logic [SUM_WIDTH-1:0] ram_rdata;

    // ------------------------------------------------------------------
    // Configuration port: cell_count at byte address 0
    // ------------------------------------------------------------------
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CELL_COUNT) ? APB_DW'(cell_count_reg) : '0;

    // Cells in use: clamp the register to the tree size
    assign len = (KW'(cell_count_reg) > KW'(CELLS)) ? KW'(CELLS) : KW'(cell_count_reg);

    // ------------------------------------------------------------------
    // Walk arithmetic: step by the lowest set bit of the one-based index
    // ------------------------------------------------------------------
    assign low_bit  = k_reg & (~k_reg + KW'(1));
    assign k_up     = k_reg + low_bit;
    assign k_down   = k_reg - low_bit;
    assign k_minus1 = k_reg - KW'(1);

    // Sign-extend the amount, then reduce to the sum width
    assign amt_wide = {{32{req.amount[AMT_W-1]}}, req.amount};
    // Results carry the low 32 bits of the wrapped sum
    assign acc_wide = 64'(acc_reg);

    // ------------------------------------------------------------------
    // Sequencer outputs: fetch the control word of this step
    // ------------------------------------------------------------------
    always_comb
    begin
        cw        = ucode(upc_reg);
        req.ready = cw.in_ready;
        accept    = cw.in_ready && req.valid;
        out_busy  = out_valid_reg && !rsp.ready;
        out_load  = (cw.out_ok || cw.out_bad) && !out_busy;
    end

    // ------------------------------------------------------------------
    // Sequencer next step: evaluate the jump condition
    // ------------------------------------------------------------------
    always_comb
    begin
        case (cw.cond)
            C_ALWAYS:    cond_true = 1'b1;
            C_IN_VALID:  cond_true = req.valid;
            C_POS_BAD:   cond_true = k_reg > len;          // position >= count
            C_QUERY:     cond_true = mode_reg;
            C_UP_MORE:   cond_true = k_up <= len;
            C_DOWN_MORE: cond_true = k_down != '0;
            C_OUT_BUSY:  cond_true = out_busy;
            C_CLR_MORE:  cond_true = clr_addr_reg != AW'(CELLS - 1);
            default:     cond_true = 1'b0;
        endcase
        upc_next = cond_true ? cw.jt : cw.jf;
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        k_next = k_reg;
        if (accept)
        begin
            k_next = KW'(req.position) + KW'(1);
        end
        else if (cw.rd_up)
        begin
            k_next = k_up;
        end
        else if (cw.rd_down)
        begin
            k_next = k_down;
        end

        acc_next = acc_reg;
        if (accept)
        begin
            acc_next = '0;
        end
        else if (apend_reg)
        begin
            acc_next = acc_reg + ram_rdata;
        end

        // Load wins over drain; drop the beat once taken
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // RAM access: read one tree entry per walk step, write back the
    // previous add step in the cycle its data returns; the clearing sweep
    // owns the write port only after reset
    // ------------------------------------------------------------------
    always_comb
    begin
        ram_re    = cw.rd_up || cw.rd_down;
        ram_we    = cw.clr || wpend_reg;
        ram_waddr = cw.clr ? clr_addr_reg : wa_reg;
        ram_wdata = cw.clr ? '0 : (ram_rdata + amt_reg);
    end

    fts_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (k_minus1[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= U_CLEAR;
            cell_count_reg <= CNT_RESET;
            clr_addr_reg   <= '0;
            wpend_reg      <= 1'b0;
            apend_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            wpend_reg     <= cw.rd_up;
            apend_reg     <= cw.rd_down;
            out_valid_reg <= out_valid_next;
            if (cw.clr)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cfg_write && (paddr[2] == REG_CELL_COUNT))
            begin
                cell_count_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        acc_reg <= acc_next;
        if (accept)
        begin
            mode_reg <= req.mode;
            amt_reg  <= amt_wide[SUM_WIDTH-1:0];
        end
        // Hold the address of the entry being read for its write-back
        if (cw.rd_up)
        begin
            wa_reg <= k_minus1[AW-1:0];
        end
        if (out_load)
        begin
            out_sum_reg <= cw.out_bad ? '0 : acc_wide[SUM_OUT_W-1:0];
            out_oor_reg <= cw.out_bad;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.prefix_sum   = out_sum_reg;
    assign rsp.out_of_range = out_oor_reg;

endmodule

// ===== verif/fenwick_tree_prefix_sum_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fenwick_tree_prefix_sum_unit_test: self-checking bench for the prefix-sum unit
// Drives add and query beats with random gaps and response back-pressure,
// predicts every prefix sum with a software binary indexed tree, and checks
// each response beat in order. The cell count is moved through several
// settings, the extremes included, while the unit is idle.
// ----------------------------------------------------------------------------
module fenwick_tree_prefix_sum_unit_test;
    import fts_pkg::*;

    localparam int CELLS          = CELLS_DEFAULT;
    localparam logic MODE_ADD     = 1'b0;
    localparam logic MODE_QUERY   = 1'b1;
    localparam logic [APB_AW-1:0] CELL_COUNT_ADDR = {REG_CELL_COUNT, 2'b00};

    localparam int IDLE_PCT        = 38;   // chance of an idle cycle on either side
    localparam int SETTLE_CYCLES   = 20;   // covers the longest add walk of 11 entries
    localparam int HOLD_OFF_CYCLES = 300;  // long response stall
    localparam int STALL_LIMIT     = 5000; // cycles with no beat before giving up
    localparam int PHASE_ITEMS     = 45;
    localparam int PHASES          = 10;

    typedef struct {
        logic [SUM_OUT_W-1:0] sum;
        logic                 flag;
    } sum_beat_t;

    // ------------------------------------------------------------------------
    // Predictor and checker: a software copy of the tree and the count in use
    // ------------------------------------------------------------------------
    class prefix_sum_checker;
        logic [SUM_OUT_W-1:0] tree_cells [CELLS];
        int unsigned          cells_in_use;
        sum_beat_t            pending_sums [$];
        int unsigned          mismatch_count;

        function new();
            foreach (tree_cells[i])
                tree_cells[i] = '0;
            cells_in_use   = CNT_RESET;
            mismatch_count = 0;
        endfunction

        // Counts above the tree size clamp to the tree size
        function void set_cell_count(input logic [CNT_W-1:0] value);
            cells_in_use = (int'(value) > CELLS) ? CELLS : int'(value);
        endfunction

        function int unsigned pending_count();
            return pending_sums.size();
        endfunction

        function void note_item(input logic mode, input logic [POS_W-1:0] pos,
                                input logic [AMT_W-1:0] amt);
            int unsigned k;
            sum_beat_t   beat;
            if (mode == MODE_ADD)
            begin
                // Adds beyond the count are dropped silently
                if (pos >= cells_in_use)
                    return;
                for (k = 32'(pos) + 1; k != 0 && k <= cells_in_use; k += k & (0 - k))
                    tree_cells[k-1] = tree_cells[k-1] + amt;
                return;
            end
            beat.sum  = '0;
            beat.flag = 1'b0;
            if (pos >= cells_in_use)
                beat.flag = 1'b1;
            else
                for (k = 32'(pos) + 1; k > 0; k -= k & (0 - k))
                    beat.sum = beat.sum + tree_cells[k-1];
            pending_sums.push_back(beat);
        endfunction

        function void check_sum(input logic [SUM_OUT_W-1:0] sum, input logic flag);
            sum_beat_t beat;
            if (pending_sums.size() == 0)
            begin
                $display("%0t: response beat with none expected: sum %h flag %b",
                         $time, sum, flag);
                mismatch_count++;
                return;
            end
            beat = pending_sums.pop_front();
            if (sum !== beat.sum)
            begin
                $display("%0t: prefix_sum expected %h actual %h", $time, beat.sum, sum);
                mismatch_count++;
            end
            if (flag !== beat.flag)
            begin
                $display("%0t: out_of_range expected %b actual %b", $time, beat.flag, flag);
                mismatch_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels, register port and the unit
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    bit          steady_run;       // no idling on either side while set
    bit          hold_off_request; // ask the response side for a long stall
    int unsigned hold_off_left;
    int unsigned quiet_cycles;

    prefix_sum_checker board = new();

    fts_req_if req_bus ();
    fts_rsp_if rsp_bus ();

    always #5 clk = ~clk;

    fenwick_tree_prefix_sum_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .rsp     (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // ------------------------------------------------------------------------
    // Monitors: sample both channels at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && req_bus.valid && req_bus.ready)
            board.note_item(req_bus.mode, req_bus.position, req_bus.amount);
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            board.check_sum(rsp_bus.prefix_sum, rsp_bus.out_of_range);
    end

    // Watchdog: count cycles in which neither channel moves a beat
    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Response side: random back-pressure, plus one long hold-off on request.
    // The hold-off is counted here, so the sender carries on regardless and
    // the unit fills up and stops taking request beats.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else if (hold_off_left != 0)
        begin
            rsp_bus.ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else if (hold_off_request)
        begin
            hold_off_request = 1'b0;
            hold_off_left   <= HOLD_OFF_CYCLES;
            rsp_bus.ready   <= 1'b0;
        end
        else
            rsp_bus.ready <= steady_run || !chance(IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one beat after a random number of idle cycles; return once the
    // beat has been taken. Valid stays high so that back-to-back beats are
    // driven without dropping it in between.
    task automatic send_item(input logic mode, input logic [POS_W-1:0] pos,
                             input logic [AMT_W-1:0] amt);
        @(negedge clk);
        while (!steady_run && chance(IDLE_PCT))
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.mode     <= mode;
        req_bus.position <= pos;
        req_bus.amount   <= amt;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    task automatic wait_for_results();
        while (board.pending_count() != 0)
            @(posedge clk);
    endtask

    // Drop valid, let every result arrive, then give a trailing add time to
    // finish its walk; no add leaves a result behind to wait for.
    task automatic quiesce();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, access cycle, then read the register back
    task automatic write_cell_count(input logic [CNT_W-1:0] value);
        logic [APB_DW-1:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CELL_COUNT_ADDR;
        pwdata  <= APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_cell_count(value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DW'(value))
        begin
            $display("%0t: cell_count read expected %h actual %h",
                     $time, APB_DW'(value), readback);
            board.mismatch_count++;
        end
    endtask

    task automatic change_cell_count(input logic [CNT_W-1:0] value);
        quiesce();
        write_cell_count(value);
    endtask

    // Extreme and small amounts half of the time, otherwise any 32-bit pattern
    function automatic logic [AMT_W-1:0] pick_amount();
        case ($urandom_range(0, 5))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return AMT_W'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    // Mostly positions inside the count in use, now and then any position
    function automatic logic [POS_W-1:0] pick_position(input int unsigned count);
        int unsigned in_use;
        in_use = (count > CELLS) ? CELLS : count;
        if (in_use == 0 || chance(12))
            return POS_W'($urandom_range(0, CELLS - 1));
        return POS_W'($urandom_range(0, in_use - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned      counts [PHASES];
        logic [CNT_W-1:0] count_now;

        // Hold every input at a known value from time zero
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_bus.valid    = 1'b0;
        req_bus.mode     = MODE_ADD;
        req_bus.position = '0;
        req_bus.amount   = '0;
        rsp_bus.ready    = 1'b0;
        steady_run       = 1'b0;
        hold_off_request = 1'b0;
        hold_off_left    = 0;
        quiet_cycles     = 0;
        counts = '{1024, 2047, 7, 1, 100, 1023, 0, 1025, 513, 0};
        counts[PHASES-1] = $urandom_range(0, 2047);

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Full tree: extremes of position and amount, wrap of a cell sum
        write_cell_count(11'd1024);
        send_item(MODE_ADD, 10'd0, 32'h7fff_ffff);
        send_item(MODE_ADD, 10'd1023, 32'h8000_0000);
        send_item(MODE_ADD, 10'd511, 32'hffff_ffff);
        send_item(MODE_ADD, 10'd0, 32'h7fff_ffff);
        send_item(MODE_QUERY, 10'd0, 32'h0);
        send_item(MODE_QUERY, 10'd511, 32'hffff_ffff);
        send_item(MODE_QUERY, 10'd1023, 32'h0);
        send_item(MODE_QUERY, 10'd512, 32'h1234_5678);
        send_item(MODE_ADD, 10'h2aa, 32'h5555_5555);
        send_item(MODE_ADD, 10'h155, 32'haaaa_aaaa);
        send_item(MODE_QUERY, 10'd1023, 32'h0);
        send_item(MODE_QUERY, 10'h155, 32'h0);

        // Zero cells: adds dropped, every query flagged
        change_cell_count(11'd0);
        send_item(MODE_ADD, 10'd5, 32'd100);
        send_item(MODE_QUERY, 10'd0, 32'h0);
        send_item(MODE_QUERY, 10'd1023, 32'h0);

        // One cell: the add past it is dropped, the query past it flagged
        change_cell_count(11'd1);
        send_item(MODE_ADD, 10'd0, 32'd9);
        send_item(MODE_ADD, 10'd1, 32'd9);
        send_item(MODE_QUERY, 10'd0, 32'h0);
        send_item(MODE_QUERY, 10'd1, 32'h0);

        // Largest count clamps to the tree size; sums kept from before
        change_cell_count(11'd2047);
        send_item(MODE_QUERY, 10'd1023, 32'h0);
        send_item(MODE_ADD, 10'd1023, 32'd1);
        send_item(MODE_QUERY, 10'd1023, 32'h0);

        // Last position just out of range
        change_cell_count(11'd1023);
        send_item(MODE_ADD, 10'd1023, 32'd5);
        send_item(MODE_QUERY, 10'd1023, 32'h0);
        send_item(MODE_QUERY, 10'd1022, 32'h0);

        // Random phases, one cell count each
        for (int p = 0; p < PHASES; p++)
        begin
            count_now = CNT_W'(counts[p]);
            change_cell_count(count_now);
            steady_run = (p == 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Stall the response side while beats keep coming
                if (p == 1 && i == 10)
                    hold_off_request = 1'b1;
                // Pause the sender until every result is back
                if (p == 0 && i == 20)
                begin
                    @(negedge clk);
                    req_bus.valid <= 1'b0;
                    wait_for_results();
                end
                send_item(chance(50) ? MODE_QUERY : MODE_ADD,
                          pick_position(counts[p]), pick_amount());
            end
            steady_run = 1'b0;
        end

        quiesce();
        if (board.mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
